// ===== sv/ita_pkg.sv =====
// Shared types, command codes and the digit-to-ASCII lookup for the integer
// to ASCII formatter. No dependencies; imported by every other file.
`default_nettype none

package ita_pkg;

  // Conversion command codes as they arrive on the input channel.
  localparam logic [2:0] CMD_SDEC  = 3'd0;
  localparam logic [2:0] CMD_UDEC  = 3'd1;
  localparam logic [2:0] CMD_HEXLO = 3'd2;
  localparam logic [2:0] CMD_HEXUP = 3'd3;
  localparam logic [2:0] CMD_PTR   = 3'd4;

  localparam int unsigned MaxChars = 16;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;

  // Reciprocal of ten for a 32-bit dividend: q = (x * RecipTen) >> RecipShift.
  localparam logic [31:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  // One classified item waiting for conversion.
  typedef struct packed {
    logic [63:0] mag;    // magnitude to convert
    logic        neg;    // emit a leading minus sign
    logic        dec;    // radix ten when set, else sixteen
    logic        upper;  // upper-case hex letters
  } conv_item_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? ChUpA : ChLowA;
    if (d < 4'd10) begin
      digit_char = ChZero + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d - 4'd10};
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/ita_front.sv =====
// Front end of the formatter: accepts input transactions, drops unused
// commands and turns the rest into a magnitude plus conversion flags.
// Depends on ita_pkg.
`default_nettype none

module ita_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_command,
  input  wire logic [63:0]        in_value,
  input  wire logic               q_full,
  output logic                    q_push,
  output ita_pkg::conv_item_t     q_item
);
  import ita_pkg::*;

  logic [31:0] low;
  logic        known;

  assign low      = in_value[31:0];
  assign in_ready = !q_full;

  always_comb begin
    q_item.mag   = {32'd0, low};
    q_item.neg   = 1'b0;
    q_item.dec   = 1'b0;
    q_item.upper = 1'b0;
    known        = 1'b1;
    unique case (in_command)
      CMD_SDEC: begin
        q_item.dec = 1'b1;
        q_item.neg = low[31];
        if (low[31]) begin
          q_item.mag = {32'd0, (~low) + 32'd1};
        end
      end
      CMD_UDEC: begin
        q_item.dec = 1'b1;
      end
      CMD_HEXLO: begin
      end
      CMD_HEXUP: begin
        q_item.upper = 1'b1;
      end
      CMD_PTR: begin
        q_item.mag = in_value;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unused commands complete their transaction but produce no text.
  assign q_push = in_valid && in_ready && known;

endmodule

`default_nettype wire

// ===== sv/ita_queue.sv =====
// Small FIFO of classified items between the front and back ends.
// Depends on ita_pkg.
`default_nettype none

module ita_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire ita_pkg::conv_item_t push_item,
  output logic                     full,
  input  wire logic                pop,
  output logic                     pop_valid,
  output ita_pkg::conv_item_t      pop_item
);
  import ita_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  conv_item_t        mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == CntW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ita_back.sv =====
// Back end of the formatter: peels digits off one per cycle into a small
// buffer, then emits sign and digits most significant first through an
// output register. Depends on ita_pkg.
`default_nettype none

module ita_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire ita_pkg::conv_item_t q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_character,
  output logic [4:0]               out_position,
  output logic                     out_last
);
  import ita_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t       state_r, state_nxt;
  logic [63:0]  mag_r, mag_nxt;
  logic         neg_r, neg_nxt;
  logic         dec_r, dec_nxt;
  logic         upper_r, upper_nxt;
  logic [4:0]   ndig_r, ndig_nxt;
  logic [3:0]   rd_idx_r, rd_idx_nxt;
  logic         sign_pend_r, sign_pend_nxt;
  logic [4:0]   pos_r, pos_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_char_r, out_char_nxt;
  logic [4:0]   out_pos_r, out_pos_nxt;
  logic         out_last_r, out_last_nxt;

  logic [3:0]   dig_r [MaxChars];

  logic [63:0]  prod;
  logic [63:0]  quot;
  logic [3:0]   q_lo, ten_lo, digit;
  logic [63:0]  mag_step;
  logic         dig_we;
  logic         out_load;

  // Divide by ten through the reciprocal; the remainder only needs four bits.
  assign prod   = mag_r[31:0] * RecipTen;
  assign quot   = {35'd0, prod[63:RecipShift]};
  assign q_lo   = quot[3:0];
  assign ten_lo = (q_lo << 3) + (q_lo << 1);
  assign digit  = dec_r ? (mag_r[3:0] - ten_lo) : mag_r[3:0];
  assign mag_step = dec_r ? quot : {4'd0, mag_r[63:4]};

  assign dig_we   = (state_r == S_CONV);
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_r[ndig_r[3:0]] <= digit;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    dec_nxt       = dec_r;
    upper_nxt     = upper_r;
    ndig_nxt      = ndig_r;
    rd_idx_nxt    = rd_idx_r;
    sign_pend_nxt = sign_pend_r;
    pos_nxt       = pos_r;
    out_char_nxt  = out_char_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          mag_nxt   = q_item.mag;
          neg_nxt   = q_item.neg;
          dec_nxt   = q_item.dec;
          upper_nxt = q_item.upper;
          ndig_nxt  = 5'd0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        mag_nxt  = mag_step;
        ndig_nxt = ndig_r + 5'd1;
        if (mag_step == 64'd0 || ndig_r == 5'(MaxChars - 1)) begin
          rd_idx_nxt    = ndig_r[3:0];
          sign_pend_nxt = neg_r;
          pos_nxt       = 5'd0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r + 5'd1;
          pos_nxt       = pos_r + 5'd1;
          if (sign_pend_r) begin
            out_char_nxt  = ChMinus;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = digit_char(dig_r[rd_idx_r], upper_r);
            out_last_nxt = (rd_idx_r == 4'd0);
            rd_idx_nxt   = rd_idx_r - 4'd1;
            if (rd_idx_r == 4'd0) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      ndig_r      <= 5'd0;
      rd_idx_r    <= 4'd0;
      pos_r       <= 5'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
      ndig_r      <= ndig_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pos_r       <= pos_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    dec_r      <= dec_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_position  = out_pos_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// ===== sv/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: front end, item queue and
// back end. Depends on ita_pkg, ita_front, ita_queue and ita_back.
`default_nettype none

// Each input transaction carries a command and a 64-bit value; the block
// answers with one output transaction per character of the value's text,
// most significant character first, with no leading zeros (zero gives "0").
// Commands: 0 signed 32-bit decimal with a leading minus sign, 1 unsigned
// 32-bit decimal, 2 and 3 32-bit hex in lower and upper case, 4 64-bit
// lower-case hex. Commands 5 to 7 are accepted and produce nothing. Every
// character carries its one-based position, and the final one has out_last
// set, so its position is the length of the text. The front end classifies
// an input in the cycle it arrives and parks it in a QUEUE_DEPTH-entry queue,
// so inputs are taken one per cycle while the queue has room. The back end
// works on one value at a time: it picks the value up, peels off one digit
// per cycle (a single reciprocal multiplier for radix ten, a nibble shift for
// hex), then sends one character per cycle through the output register
// while the receiver is ready.

module integer_to_ascii_formatter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_character,
  output logic [4:0]       out_position,
  output logic             out_last
);
  import ita_pkg::*;

  conv_item_t push_item, pop_item;
  logic       push, full, pop, pop_valid;

  ita_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_value   (in_value),
    .q_full     (full),
    .q_push     (push),
    .q_item     (push_item)
  );

  ita_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  ita_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (pop_valid),
    .q_item        (pop_item),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_position  (out_position),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for integer_to_ascii_formatter: every command and
// value transaction is converted to text here and compared per character.
// Depends on ita_pkg and the RTL of integer_to_ascii_formatter.
`timescale 1ns / 1ps

module tb;
  import ita_pkg::*;

  // Commands above CMD_PTR are unused; the block takes them and stays silent.
  localparam logic [2:0] CMD_FIRST_SPARE = CMD_PTR + 3'd1;
  localparam logic [2:0] CMD_LAST_SPARE  = 3'd7;

  // Cycles with no transaction on either channel before the run is declared
  // hung. The slowest item is a sixteen-digit pointer, and the receiver's
  // random stalls stretch its conversion, so this limit is far beyond it.
  localparam int unsigned STALL_LIMIT   = 2000;
  // Quiet time after the last expected character, so that a stray extra
  // character from a late item still shows up.
  localparam int unsigned TAIL_CYCLES   = 64;
  localparam int unsigned RANDOM_ITEMS  = 330;
  localparam int unsigned IDLE_PERCENT  = 19;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] value;
  } conv_request_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [4:0] pos;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = CMD_SDEC;
  logic [63:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_character;
  logic [4:0]  out_position;
  logic        out_last;

  conv_request_t requests_pending[$];
  text_char_t    chars_expected[$];
  int unsigned   n_items_in = 0;
  int unsigned   n_chars_out = 0;
  int unsigned   n_errors = 0;
  int unsigned   stall_cycles = 0;

  // The long stretches with no idling are tied to transaction counts, so they
  // land in the middle of the random part whatever the stall pattern was.
  wire calm_in  = (n_items_in >= 120) && (n_items_in < 200);
  wire calm_out = (n_chars_out >= 1200) && (n_chars_out < 1800);

  integer_to_ascii_formatter u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_position  (out_position),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // Works out the text of one accepted value and appends its characters, in
  // emission order, to the queue of expected characters. Only the low word
  // counts for the 32-bit commands; signed decimal negates a negative low
  // word and puts a minus sign in front, which also covers the most negative
  // value. Unused commands produce nothing.
  function automatic void predict_text(input logic [2:0] cmd, input logic [63:0] val);
    string       digit_set;
    logic [63:0] mag;
    logic [63:0] radix;
    logic [7:0]  text[$];
    text_char_t  entry;
    int          n;
    digit_set = "0123456789abcdef";
    radix = 64'd16;
    mag = {32'd0, val[31:0]};
    case (cmd)
      CMD_SDEC: begin
        radix = 64'd10;
        if (val[31]) begin
          text.push_back(ChMinus);
          mag = {32'd0, 32'd0 - val[31:0]};
        end
      end
      CMD_UDEC: radix = 64'd10;
      CMD_HEXLO: ;
      CMD_HEXUP: digit_set = "0123456789ABCDEF";
      CMD_PTR: mag = val;
      default: return;
    endcase
    // Digits come out least significant first; inserting each one right
    // after the optional sign keeps the text most significant first.
    n = text.size();
    do begin
      text.insert(n, digit_set[mag % radix]);
      mag = mag / radix;
    end while (mag != 0);
    foreach (text[i]) begin
      entry.ch   = text[i];
      entry.pos  = 5'(i + 1);
      entry.last = (i == text.size() - 1);
      chars_expected.push_back(entry);
    end
  endfunction

  function automatic void queue_request(input logic [2:0] cmd, input logic [63:0] value);
    conv_request_t req;
    req.cmd   = cmd;
    req.value = value;
    requests_pending.push_back(req);
  endfunction

  // Random value with its weight on the interesting spots: full-width noise,
  // values of random bit length, tiny values, the region around zero and the
  // sign bit, and decimal digit-count boundaries. The high word stays random
  // in all but the bit-length case, so the 32-bit commands see garbage there.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int unsigned pw;
    v = {$urandom, $urandom};
    case ($urandom_range(4))
      0: ;
      1: v = v >> $urandom_range(63);
      2: v[31:0] = $urandom_range(20);
      3: v[31:0] = {$urandom_range(1) == 1, 31'd0} - $urandom_range(2);
      default: begin
        pw = 1;
        repeat ($urandom_range(9, 1)) pw = pw * 10;
        v[31:0] = pw + $urandom_range(2) - 1;
      end
    endcase
    return v;
  endfunction

  function automatic logic [2:0] random_command();
    if ($urandom_range(99) < 8) begin
      return 3'($urandom_range(CMD_LAST_SPARE, CMD_FIRST_SPARE));
    end
    return 3'($urandom_range(CMD_PTR, CMD_SDEC));
  endfunction

  // Driver. A transaction is taken when valid and ready are both high at an
  // edge; only then, or while valid is low, is the next item considered, so
  // valid and payload hold steady while the block stalls. The prediction is
  // made at the moment of acceptance, from the payload that was accepted.
  always @(posedge clk) begin : drive_requests
    conv_request_t req;
    logic          send;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_text(in_command, in_value);
        n_items_in++;
      end
      send = (requests_pending.size() != 0) &&
             (calm_in || $urandom_range(99) >= IDLE_PERCENT);
      if (send) begin
        req = requests_pending.pop_front();
        in_valid   <= 1'b1;
        in_command <= req.cmd;
        in_value   <= req.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor. Each accepted character is checked field by field against the
  // oldest expectation; ready is re-rolled every cycle to stall at random.
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_chars_out++;
        if (chars_expected.size() == 0) begin
          $error("unexpected character %h at position %0d", out_character, out_position);
          n_errors++;
        end else begin
          want = chars_expected.pop_front();
          if (out_character !== want.ch) begin
            $error("character mismatch: expected %h, actual %h", want.ch, out_character);
            n_errors++;
          end
          if (out_position !== want.pos) begin
            $error("position mismatch: expected %0d, actual %0d", want.pos, out_position);
            n_errors++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_last);
            n_errors++;
          end
        end
      end
      out_ready <= calm_out || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: a run in which neither channel moves for too long is hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Blocks until every queued item has been taken and every expected
  // character has come back. Used as the sender's pause between phases.
  task automatic wait_for_drain();
    while (requests_pending.size() != 0 || in_valid || chars_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    // Directed part: zero in every mode, the signed extremes including the
    // most negative value, unsigned maximum, digit-count boundaries, hex in
    // both cases with a dirty high word, pointer extremes and the unused
    // commands, which must produce nothing.
    queue_request(CMD_SDEC, 64'd0);
    queue_request(CMD_UDEC, 64'd0);
    queue_request(CMD_HEXLO, 64'd0);
    queue_request(CMD_HEXUP, 64'd0);
    queue_request(CMD_PTR, 64'd0);
    queue_request(CMD_SDEC, 64'h0000_0000_7FFF_FFFF);
    queue_request(CMD_SDEC, 64'h0000_0000_8000_0000);
    queue_request(CMD_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_request(CMD_SDEC, 64'hA5A5_A5A5_0000_0009);
    queue_request(CMD_UDEC, 64'h0000_0000_FFFF_FFFF);
    queue_request(CMD_UDEC, 64'd9);
    queue_request(CMD_UDEC, 64'd10);
    queue_request(CMD_UDEC, 64'h1234_5678_3B9A_CA00);
    queue_request(CMD_HEXLO, 64'hFFFF_FFFF_DEAD_BEEF);
    queue_request(CMD_HEXUP, 64'hFFFF_FFFF_DEAD_BEEF);
    queue_request(CMD_HEXUP, 64'h0000_0000_ABCD_EF01);
    queue_request(CMD_HEXLO, 64'h0000_0001_0000_000F);
    queue_request(CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_request(CMD_PTR, 64'h0123_4567_89AB_CDEF);
    queue_request(CMD_PTR, 64'h8000_0000_0000_0001);
    queue_request(CMD_PTR, 64'd1);
    queue_request(CMD_FIRST_SPARE, 64'h0000_0000_0000_0042);
    queue_request(3'(CMD_FIRST_SPARE + 3'd1), 64'hFFFF_FFFF_FFFF_FFFF);
    queue_request(CMD_LAST_SPARE, 64'd0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The sender holds off until all directed text is back before random
    // traffic starts, and once more halfway through the random part.
    wait_for_drain();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        wait_for_drain();
      end
      @(negedge clk);
      queue_request(random_command(), random_value());
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (chars_expected.size() != 0) begin
      $error("%0d expected characters never arrived", chars_expected.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
